### src/art_pkg.sv
package art_pkg;

  typedef enum logic [1:0] {
    OP_MAP     = 2'd0,
    OP_UNMAP   = 2'd1,
    OP_PROTECT = 2'd2,
    OP_CHECK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_ALIGN   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_OVERLAP = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_SCAN,
    S_DECIDE,
    S_WRITE,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    K_MAP,
    K_UNMAP_WALK,
    K_UNMAP_FREE,
    K_PROTECT,
    K_CHECK
  } pass_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic [7:0]  flags;
  } entry_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] region_count;
  } result_t;

endpackage

### src/address_region_table.sv
// Address region table: a table of virtual address regions with map, unmap,
// protect and range check requests.
// Input channel: in_valid/in_stall with op, address, length and flags. A
// request is taken only while the block is idle; in_stall is high otherwise.
// Output channel: out_valid/out_stall with status and region_count. Every
// request gives exactly one result. A held result does not keep the next
// request from being taken.
// Region base, size and flags live in a one-port-read, one-port-write
// memory with registered read data; the in-use bits are flip-flops.
// Each pass reads all REGION_SLOTS entries. Map and protect take one pass,
// then write the table if they succeed. Unmap takes one pass per region
// walked plus one freeing pass; check takes one pass per region walked.
// Requests settled by the argument checks go to the result without a pass.
// cfg_write_en writes the user flag mask from cfg_write_data; the user must
// do so only while idle, as the block itself does not enforce it.
// Reset empties the table at once and sets the user flag mask to 4.
// While out_stall is high the result holds, and a finished request waits
// for the output register before the block accepts another.
module address_region_table #(
  parameter int REGION_SLOTS = 32,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [63:0] address,
  input  logic [63:0] length,
  input  logic [7:0]  flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [5:0]  region_count,
  input  logic        cfg_write_en,
  input  logic [7:0]  cfg_write_data
);

  localparam int IW = $clog2(REGION_SLOTS);

  logic [7:0] user_flag_mask;
  logic busy, res_free, res_load;
  art_pkg::result_t res;
  logic mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  art_pkg::entry_t mem_wdata, mem_rdata;

  assign in_stall = busy;
  assign res_free = !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      user_flag_mask <= 8'd4;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        user_flag_mask <= cfg_write_data;
      end
      if (res_load) begin
        out_valid    <= 1'b1;
        status       <= res.status;
        region_count <= res.region_count;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  art_ctrl #(
    .REGION_SLOTS(REGION_SLOTS),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_fire(in_valid && !in_stall),
    .op(op),
    .address(address),
    .length(length),
    .flags(flags),
    .user_mask(user_flag_mask),
    .busy(busy),
    .res_free(res_free),
    .res_load(res_load),
    .res(res),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  art_store #(
    .REGION_SLOTS(REGION_SLOTS)
  ) u_store (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

### src/art_store.sv
module art_store #(
  parameter int REGION_SLOTS = 32
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(REGION_SLOTS)-1:0] waddr,
  input  art_pkg::entry_t                 wdata,
  input  logic [$clog2(REGION_SLOTS)-1:0] raddr,
  output art_pkg::entry_t                 rdata
);

  art_pkg::entry_t mem [REGION_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/art_ctrl.sv
module art_ctrl #(
  parameter int REGION_SLOTS = 32,
  parameter int PAGE_BYTES   = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_fire,
  input  logic [1:0]                      op,
  input  logic [63:0]                     address,
  input  logic [63:0]                     length,
  input  logic [7:0]                      flags,
  input  logic [7:0]                      user_mask,
  output logic                            busy,
  input  logic                            res_free,
  output logic                            res_load,
  output art_pkg::result_t                res,
  output logic                            mem_we,
  output logic [$clog2(REGION_SLOTS)-1:0] mem_waddr,
  output art_pkg::entry_t                 mem_wdata,
  output logic [$clog2(REGION_SLOTS)-1:0] mem_raddr,
  input  art_pkg::entry_t                 mem_rdata
);

  localparam int IW = $clog2(REGION_SLOTS);
  localparam int CW = $clog2(REGION_SLOTS + 1);
  localparam int PB = $clog2(PAGE_BYTES);

  art_pkg::state_t state, state_next;
  art_pkg::pass_t  kind;

  logic [1:0]  op_q;
  logic [63:0] a_q, len_q, end_q, cur;
  logic [7:0]  fl_q;
  logic [IW:0] scan_cnt;
  logic        ev_valid;
  logic [IW-1:0] ev_idx;
  logic        fnd, ovl, bad;
  logic [IW-1:0] fidx, free0, free1, widx, post_idx;
  logic [63:0] fbase, fend;
  logic [7:0]  fflags;
  logic [1:0]  nfree;
  logic        do_pre, do_post;
  logic [2:0]  st_code;
  logic [REGION_SLOTS-1:0] slot_used;
  logic [CW-1:0] count;

  logic [64:0] sum;
  logic        misal, wrap_in;
  logic        pre_scan;
  logic [2:0]  pre_status;
  art_pkg::pass_t pre_kind;

  logic        u, wr, user, has_req, has_cur;
  logic [64:0] rsum;
  logic [63:0] re;
  logic        issue, scan_last;

  logic        dec_done, dec_write, dec_free;
  logic [2:0]  dec_status;
  logic [1:0]  need;

  assign busy = (state != art_pkg::S_IDLE);

  assign sum     = {1'b0, a_q} + {1'b0, len_q};
  assign wrap_in = sum[64];
  assign misal   = (|a_q[PB-1:0]) | (|len_q[PB-1:0]);

  always_comb begin
    pre_scan   = 1'b0;
    pre_status = art_pkg::ST_OK;
    pre_kind   = art_pkg::K_MAP;
    if (op_q == art_pkg::OP_CHECK) begin
      pre_kind = art_pkg::K_CHECK;
      if (len_q == 64'd0) begin
        pre_status = art_pkg::ST_OK;
      end else if (a_q == 64'd0) begin
        pre_status = art_pkg::ST_ZERO;
      end else if (wrap_in) begin
        pre_status = art_pkg::ST_RANGE;
      end else begin
        pre_scan = 1'b1;
      end
    end else if (a_q == 64'd0 || len_q == 64'd0) begin
      pre_status = art_pkg::ST_ZERO;
    end else if (misal) begin
      pre_status = art_pkg::ST_ALIGN;
    end else if (wrap_in) begin
      pre_status = art_pkg::ST_RANGE;
    end else begin
      pre_scan = 1'b1;
      case (op_q)
        art_pkg::OP_MAP:     pre_kind = art_pkg::K_MAP;
        art_pkg::OP_UNMAP:   pre_kind = art_pkg::K_UNMAP_WALK;
        default:             pre_kind = art_pkg::K_PROTECT;
      endcase
    end
  end

  assign issue     = (state == art_pkg::S_SCAN) && (scan_cnt < (IW+1)'(REGION_SLOTS));
  assign scan_last = ev_valid && (ev_idx == IW'(REGION_SLOTS - 1));

  assign u       = slot_used[ev_idx];
  assign rsum    = {1'b0, mem_rdata.base} + {1'b0, mem_rdata.size};
  assign wr      = rsum[64];
  assign re      = rsum[63:0];
  assign user    = |(mem_rdata.flags & user_mask);
  assign has_req = ((mem_rdata.flags & fl_q) == fl_q);
  assign has_cur = (cur >= mem_rdata.base) && (cur < re);

  assign need = {1'b0, (a_q != fbase)} + {1'b0, (fend != end_q)};

  always_comb begin
    dec_done   = 1'b0;
    dec_write  = 1'b0;
    dec_free   = 1'b0;
    dec_status = art_pkg::ST_OK;
    case (kind)
      art_pkg::K_MAP: begin
        if (ovl) begin
          dec_done = 1'b1; dec_status = art_pkg::ST_OVERLAP;
        end else if (nfree == 2'd0) begin
          dec_done = 1'b1; dec_status = art_pkg::ST_FULL;
        end else begin
          dec_write = 1'b1;
        end
      end
      art_pkg::K_UNMAP_WALK: begin
        if (bad || !fnd) begin
          dec_done = 1'b1; dec_status = art_pkg::ST_ALIGN;
        end else if (fend >= end_q) begin
          dec_free = 1'b1;
        end
      end
      art_pkg::K_PROTECT: begin
        if (!fnd) begin
          dec_done = 1'b1; dec_status = art_pkg::ST_RANGE;
        end else if (need > nfree) begin
          dec_done = 1'b1; dec_status = art_pkg::ST_FULL;
        end else begin
          dec_write = 1'b1;
        end
      end
      art_pkg::K_CHECK: begin
        if (!fnd) begin
          dec_done = 1'b1; dec_status = art_pkg::ST_RANGE;
        end else if (fend >= end_q) begin
          dec_done = 1'b1;
        end
      end
      default: begin
        dec_done = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      art_pkg::S_IDLE:   if (in_fire) state_next = art_pkg::S_PRE;
      art_pkg::S_PRE:    state_next = pre_scan ? art_pkg::S_SCAN : art_pkg::S_DONE;
      art_pkg::S_SCAN:   if (scan_last) state_next = art_pkg::S_DECIDE;
      art_pkg::S_DECIDE: begin
        if (dec_done) begin
          state_next = art_pkg::S_DONE;
        end else if (dec_write) begin
          state_next = art_pkg::S_WRITE;
        end else begin
          state_next = art_pkg::S_SCAN;
        end
      end
      art_pkg::S_WRITE:  if (!do_pre && !do_post) state_next = art_pkg::S_DONE;
      art_pkg::S_DONE:   if (res_free) state_next = art_pkg::S_IDLE;
      default:           state_next = art_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = (state == art_pkg::S_WRITE);
    mem_raddr = scan_cnt[IW-1:0];
    if (do_pre) begin
      mem_waddr = free0;
      mem_wdata = '{base: fbase, size: a_q - fbase, flags: fflags};
    end else if (do_post) begin
      mem_waddr = post_idx;
      mem_wdata = '{base: end_q, size: fend - end_q, flags: fflags};
    end else begin
      mem_waddr = widx;
      mem_wdata = '{base: a_q, size: len_q, flags: fl_q};
    end
    res_load         = (state == art_pkg::S_DONE) && res_free;
    res.status       = st_code;
    res.region_count = 6'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= art_pkg::S_IDLE;
      slot_used <= '0;
      count     <= '0;
      ev_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      ev_valid <= issue;
      if (issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      ev_idx <= scan_cnt[IW-1:0];
      case (state)
        art_pkg::S_IDLE: begin
          if (in_fire) begin
            op_q  <= op;
            a_q   <= address;
            len_q <= length;
            fl_q  <= flags;
          end
        end
        art_pkg::S_PRE: begin
          end_q    <= sum[63:0];
          cur      <= a_q;
          kind     <= pre_kind;
          st_code  <= pre_status;
          scan_cnt <= '0;
          fnd      <= 1'b0;
          ovl      <= 1'b0;
          bad      <= 1'b0;
          nfree    <= 2'd0;
        end
        art_pkg::S_SCAN: begin
          if (ev_valid) begin
            if (!u && nfree != 2'd2) begin
              if (nfree == 2'd0) begin
                free0 <= ev_idx;
              end else begin
                free1 <= ev_idx;
              end
              nfree <= nfree + 2'd1;
            end
            case (kind)
              art_pkg::K_MAP: begin
                if (u && (wr || !(end_q <= mem_rdata.base || re <= a_q))) begin
                  ovl <= 1'b1;
                end
              end
              art_pkg::K_UNMAP_WALK: begin
                if (u && !wr && has_cur && !fnd) begin
                  fnd  <= 1'b1;
                  fend <= re;
                  if (mem_rdata.base < a_q || re > end_q) begin
                    bad <= 1'b1;
                  end
                end
              end
              art_pkg::K_UNMAP_FREE: begin
                if (u && !wr && mem_rdata.base >= a_q && re <= end_q) begin
                  slot_used[ev_idx] <= 1'b0;
                  count <= count - 1'b1;
                end
              end
              art_pkg::K_PROTECT: begin
                if (u && user && !wr && !fnd && a_q >= mem_rdata.base && end_q <= re) begin
                  fnd    <= 1'b1;
                  fidx   <= ev_idx;
                  fbase  <= mem_rdata.base;
                  fend   <= re;
                  fflags <= mem_rdata.flags;
                end
              end
              art_pkg::K_CHECK: begin
                if (u && user && has_req && !wr && has_cur && !fnd) begin
                  fnd  <= 1'b1;
                  fend <= re;
                end
              end
              default: begin
              end
            endcase
          end
        end
        art_pkg::S_DECIDE: begin
          st_code  <= dec_status;
          scan_cnt <= '0;
          fnd      <= 1'b0;
          nfree    <= 2'd0;
          cur      <= fend;
          if (dec_free) begin
            kind <= art_pkg::K_UNMAP_FREE;
          end
          do_pre  <= 1'b0;
          do_post <= 1'b0;
          if (dec_write) begin
            if (kind == art_pkg::K_MAP) begin
              widx <= free0;
            end else begin
              widx     <= fidx;
              do_pre   <= (a_q != fbase);
              do_post  <= (fend != end_q);
              post_idx <= (a_q != fbase) ? free1 : free0;
            end
          end
        end
        art_pkg::S_WRITE: begin
          slot_used[mem_waddr] <= 1'b1;
          if (do_pre) begin
            do_pre <= 1'b0;
            count  <= count + 1'b1;
          end else if (do_post) begin
            do_post <= 1'b0;
            count   <= count + 1'b1;
          end else if (kind == art_pkg::K_MAP) begin
            count <= count + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### tb/address_region_table_tb.sv
`timescale 1ns / 1ps

module address_region_table_tb;

  localparam int SLOTS = 32;
  localparam logic [63:0] PAGE = 64'd4096;
  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 6000000;

  typedef struct {
    art_pkg::op_t     op;
    logic [63:0]      address;
    logic [63:0]      length;
    logic [7:0]       flags;
    logic             known;
    art_pkg::status_t status;
    logic [5:0]       count;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = 2'd0;
  logic [63:0] address = 64'd0;
  logic [63:0] length = 64'd0;
  logic [7:0]  flags = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [5:0]  region_count;
  logic        cfg_write_en = 1'b0;
  logic [7:0]  cfg_write_data = 8'd0;

  logic        mdl_used [SLOTS];
  logic [63:0] mdl_base [SLOTS];
  logic [63:0] mdl_size [SLOTS];
  logic [7:0]  mdl_flags [SLOTS];
  logic [7:0]  mdl_user_mask;

  art_pkg::result_t pending_results [$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  address_region_table DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .address(address), .length(length), .flags(flags),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .region_count(region_count),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[address_region_table] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  always @(posedge clk) begin
    art_pkg::result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("result with none expected");
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status)
          report($sformatf("status %0d, expected %0d", status, exp_r.status));
        if (region_count !== exp_r.region_count)
          report($sformatf("region_count %0d, expected %0d", region_count,
                           exp_r.region_count));
      end
    end
  end

  function automatic logic limit_of(input int i, output logic [63:0] e);
    logic [64:0] s;
    s = {1'b0, mdl_base[i]} + {1'b0, mdl_size[i]};
    e = s[63:0];
    return !s[64];
  endfunction

  function automatic logic user_region(input int i);
    return (mdl_flags[i] & mdl_user_mask) != 8'd0;
  endfunction

  function automatic logic [5:0] used_count();
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < SLOTS; i++) if (mdl_used[i]) n++;
    return n;
  endfunction

  function automatic art_pkg::status_t table_map(input logic [63:0] a,
                                                 input logic [63:0] len,
                                                 input logic [7:0] fl);
    logic [63:0] e, re;
    e = a + len;
    for (int i = 0; i < SLOTS; i++) begin
      if (!mdl_used[i]) continue;
      if (!limit_of(i, re)) return art_pkg::ST_OVERLAP;
      if (!(e <= mdl_base[i] || re <= a)) return art_pkg::ST_OVERLAP;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!mdl_used[i]) begin
        mdl_used[i] = 1'b1;
        mdl_base[i] = a;
        mdl_size[i] = len;
        mdl_flags[i] = fl;
        return art_pkg::ST_OK;
      end
    end
    return art_pkg::ST_FULL;
  endfunction

  function automatic art_pkg::status_t table_unmap(input logic [63:0] a,
                                                   input logic [63:0] len);
    logic [63:0] e, cur, re;
    logic found;
    e = a + len;
    cur = a;
    while (cur < e) begin
      found = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!mdl_used[i] || !limit_of(i, re)) continue;
        if (cur < mdl_base[i] || cur >= re) continue;
        if (mdl_base[i] < a || re > e) return art_pkg::ST_ALIGN;
        cur = re;
        found = 1'b1;
        break;
      end
      if (!found) return art_pkg::ST_ALIGN;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!mdl_used[i] || !limit_of(i, re)) continue;
      if (mdl_base[i] >= a && re <= e) mdl_used[i] = 1'b0;
    end
    return art_pkg::ST_OK;
  endfunction

  function automatic art_pkg::status_t table_protect(input logic [63:0] a,
                                                     input logic [63:0] len,
                                                     input logic [7:0] fl);
    logic [63:0] e, re, pre, post, ob;
    logic [7:0] of;
    int free_slot [2];
    int need, got, s;
    e = a + len;
    for (int i = 0; i < SLOTS; i++) begin
      if (!mdl_used[i] || !user_region(i) || !limit_of(i, re)) continue;
      if (a < mdl_base[i] || e > re) continue;
      pre = a - mdl_base[i];
      post = re - e;
      need = (pre != 0) + (post != 0);
      got = 0;
      for (int j = 0; j < SLOTS && got < need; j++)
        if (!mdl_used[j]) begin
          free_slot[got] = j;
          got++;
        end
      if (got < need) return art_pkg::ST_FULL;
      ob = mdl_base[i];
      of = mdl_flags[i];
      s = 0;
      if (pre != 0) begin
        mdl_used[free_slot[0]] = 1'b1;
        mdl_base[free_slot[0]] = ob;
        mdl_size[free_slot[0]] = pre;
        mdl_flags[free_slot[0]] = of;
        s = 1;
      end
      if (post != 0) begin
        mdl_used[free_slot[s]] = 1'b1;
        mdl_base[free_slot[s]] = e;
        mdl_size[free_slot[s]] = post;
        mdl_flags[free_slot[s]] = of;
      end
      mdl_base[i] = a;
      mdl_size[i] = len;
      mdl_flags[i] = fl;
      return art_pkg::ST_OK;
    end
    return art_pkg::ST_RANGE;
  endfunction

  function automatic art_pkg::status_t table_check(input logic [63:0] a,
                                                   input logic [63:0] len,
                                                   input logic [7:0] req);
    logic [63:0] e, cur, re, me;
    logic found;
    if (len == 0) return art_pkg::ST_OK;
    if (a == 0) return art_pkg::ST_ZERO;
    if (a > MAX64 - len) return art_pkg::ST_RANGE;
    e = a + len;
    cur = a;
    while (cur < e) begin
      found = 1'b0;
      me = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!mdl_used[i] || !user_region(i)) continue;
        if ((mdl_flags[i] & req) != req) continue;
        if (!limit_of(i, re)) continue;
        if (cur < mdl_base[i] || cur >= re) continue;
        me = re;
        found = 1'b1;
        break;
      end
      if (!found) return art_pkg::ST_RANGE;
      cur = (me < e) ? me : e;
    end
    return art_pkg::ST_OK;
  endfunction

  function automatic art_pkg::result_t apply_request(input art_pkg::op_t o,
                                                     input logic [63:0] a,
                                                     input logic [63:0] len,
                                                     input logic [7:0] fl);
    art_pkg::result_t r;
    art_pkg::status_t st;
    if (o == art_pkg::OP_CHECK) st = table_check(a, len, fl);
    else if (a == 0 || len == 0) st = art_pkg::ST_ZERO;
    else if ((a & (PAGE - 1)) != 0 || (len & (PAGE - 1)) != 0) st = art_pkg::ST_ALIGN;
    else if (a > MAX64 - len) st = art_pkg::ST_RANGE;
    else if (o == art_pkg::OP_MAP) st = table_map(a, len, fl);
    else if (o == art_pkg::OP_UNMAP) st = table_unmap(a, len);
    else st = table_protect(a, len, fl);
    r.status = st;
    r.region_count = used_count();
    return r;
  endfunction

  task automatic send_request(input art_pkg::op_t o, input logic [63:0] a,
                              input logic [63:0] len, input logic [7:0] fl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    address <= a;
    length <= len;
    flags <= fl;
    pending_results.push_back(apply_request(o, a, len, fl));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_mask(input logic [7:0] m);
    drain();
    cfg_write_en <= 1'b1;
    cfg_write_data <= m;
    mdl_user_mask = m;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_page_addr();
    return 64'({$urandom_range(0, 63), 12'd0}) + 64'h0010_0000;
  endfunction

  task automatic random_request();
    art_pkg::op_t o;
    logic [63:0] a, len;
    logic [7:0] fl;
    int k, pick;
    o = art_pkg::op_t'($urandom_range(3));
    a = rand_page_addr();
    len = 64'({$urandom_range(1, 8), 12'd0});
    fl = 8'($urandom_range(255));
    if ($urandom_range(99) < 30) fl = fl | mdl_user_mask;
    k = $urandom_range(99);
    if (k < 35) begin
      pick = $urandom_range(SLOTS - 1);
      if (mdl_used[pick]) begin
        a = mdl_base[pick] + 64'({$urandom_range(0, 2), 12'd0});
        len = PAGE * 64'($urandom_range(1, 2));
        if ($urandom_range(1)) begin
          a = mdl_base[pick];
          len = mdl_size[pick];
        end
      end
    end else if (k < 42) begin
      a = {$urandom, $urandom};
      len = {$urandom, $urandom};
    end else if (k < 46) begin
      a = a + 64'($urandom_range(1, 4095));
    end else if (k < 49) begin
      a = MAX64 - PAGE + 64'd1;
    end else if (k < 51) begin
      len = '0;
    end else if (k < 53) begin
      a = '0;
    end
    if (o == art_pkg::OP_CHECK && $urandom_range(3) == 0)
      len = 64'($urandom_range(1, 20000));
    send_request(o, a, len, fl);
  endtask

  stim_t directed [] = '{
    '{art_pkg::OP_CHECK, 64'd0, 64'd0, 8'h00, 1'b1, art_pkg::ST_OK, 6'd0},
    '{art_pkg::OP_CHECK, 64'd0, 64'd5, 8'h00, 1'b1, art_pkg::ST_ZERO, 6'd0},
    '{art_pkg::OP_CHECK, MAX64, 64'd1, 8'h00, 1'b1, art_pkg::ST_RANGE, 6'd0},
    '{art_pkg::OP_MAP, 64'd0, 64'h1000, 8'h04, 1'b1, art_pkg::ST_ZERO, 6'd0},
    '{art_pkg::OP_MAP, 64'h1000, 64'd0, 8'h04, 1'b1, art_pkg::ST_ZERO, 6'd0},
    '{art_pkg::OP_MAP, 64'h1001, 64'h1000, 8'h04, 1'b1, art_pkg::ST_ALIGN, 6'd0},
    '{art_pkg::OP_MAP, 64'h1000, 64'h0FFF, 8'h04, 1'b1, art_pkg::ST_ALIGN, 6'd0},
    '{art_pkg::OP_MAP, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 8'h04, 1'b1,
      art_pkg::ST_RANGE, 6'd0},
    '{art_pkg::OP_UNMAP, 64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_F000, 8'h00, 1'b1,
      art_pkg::ST_RANGE, 6'd0},
    '{art_pkg::OP_MAP, 64'h1000, 64'h8000, 8'h07, 1'b1, art_pkg::ST_OK, 6'd1},
    '{art_pkg::OP_MAP, 64'h2000, 64'h1000, 8'h04, 1'b1, art_pkg::ST_OVERLAP, 6'd1},
    '{art_pkg::OP_MAP, 64'hFFFF_FFFF_FFFF_E000, 64'h1000, 8'hFF, 1'b1,
      art_pkg::ST_OK, 6'd2},
    '{art_pkg::OP_CHECK, 64'h1000, 64'h8000, 8'h03, 1'b0, art_pkg::ST_OK, 6'd0},
    '{art_pkg::OP_CHECK, 64'h1000, 64'h9000, 8'h00, 1'b0, art_pkg::ST_OK, 6'd0},
    '{art_pkg::OP_PROTECT, 64'h3000, 64'h2000, 8'h05, 1'b0, art_pkg::ST_OK, 6'd0},
    '{art_pkg::OP_CHECK, 64'h1800, 64'h5000, 8'h04, 1'b0, art_pkg::ST_OK, 6'd0},
    '{art_pkg::OP_CHECK, 64'h1800, 64'h5000, 8'h02, 1'b0, art_pkg::ST_OK, 6'd0},
    '{art_pkg::OP_PROTECT, 64'h2_0000, 64'h1000, 8'h04, 1'b0, art_pkg::ST_OK, 6'd0},
    '{art_pkg::OP_UNMAP, 64'h2000, 64'h1000, 8'h00, 1'b0, art_pkg::ST_OK, 6'd0},
    '{art_pkg::OP_UNMAP, 64'h1000, 64'h8000, 8'h00, 1'b0, art_pkg::ST_OK, 6'd0},
    '{art_pkg::OP_PROTECT, 64'h1000, 64'h2000, 8'hFF, 1'b0, art_pkg::ST_OK, 6'd0},
    '{art_pkg::OP_UNMAP, 64'hFFFF_FFFF_FFFF_E000, 64'h1000, 8'hFF, 1'b0,
      art_pkg::ST_OK, 6'd0}
  };

  initial begin
    stim_t d;
    art_pkg::result_t got;
    for (int i = 0; i < SLOTS; i++) begin
      mdl_used[i] = 1'b0;
      mdl_base[i] = '0;
      mdl_size[i] = '0;
      mdl_flags[i] = '0;
    end
    mdl_user_mask = 8'd4;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      d = directed[i];
      send_request(d.op, d.address, d.length, d.flags);
      if (d.known) begin
        got = pending_results[$];
        if (got.status != d.status || got.region_count != d.count)
          report($sformatf("table row %0d disagrees with the predictor", i));
      end
    end

    // Fill the table to reach the full case.
    write_mask(8'hFF);
    for (int i = 0; i < SLOTS + 2; i++)
      send_request(art_pkg::OP_MAP, 64'h4000_0000 + i * 64'h2000, 64'h1000, 8'h81);
    send_request(art_pkg::OP_PROTECT, 64'h4000_0000, 64'h1000, 8'h01);
    send_request(art_pkg::OP_UNMAP, 64'h4000_0000, 64'h40000, 8'h00);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 50; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 50; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      write_mask(ph == 0 ? 8'h00 : ph == 1 ? 8'hFF : ph == 2 ? 8'h04 :
                 8'($urandom_range(255)));
      for (int n = 0; n < 137; n++) begin
        random_request();
        if ($urandom_range(99) == 0) drain();
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("[address_region_table] OK");
    end else begin
      $display("[address_region_table] ERROR");
    end
    $finish;
  end

endmodule
